[sv/nsfr_pkg.sv]
// shared types, constants and helper functions for the find and replace block
package nsfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 4;
    localparam int WORD_W  = 64;
    localparam int PEND_IW = $clog2(PATTERN_MAX);
    localparam int REP_IW  = $clog2(REPLACE_MAX);

    localparam int APB_DW  = 64;
    localparam int APB_AW  = 6;

    // register indexes, byte address is eight times the index
    localparam logic [2:0] REG_PATTERN_WORD   = 3'd0;
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [2:0] REG_REPLACE_WORD   = 3'd2;
    localparam logic [2:0] REG_REPLACE_LENGTH = 3'd3;
    localparam logic [2:0] REG_FIRST_ONLY     = 3'd4;

    typedef enum logic [1:0] {
        SEL_PEND = 2'd0,
        SEL_ITEM = 2'd1,
        SEL_REPL = 2'd2
    } emit_sel_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern_word;
        logic [LEN_W-1:0]  plen;
        logic [WORD_W-1:0] replace_word;
        logic [LEN_W-1:0]  rlen;
        logic              first_only;
    } cfg_t;

    typedef struct packed {
        logic      take_item;
        logic      emit;
        emit_sel_t emit_sel;
        logic      begin_repl;
        logic      finish;
    } cmd_t;

    typedef struct packed {
        logic pass_mode;
        logic count_zero;
        logic prefix_ok;
        logic full_match;
        logic rep_done;
        logic can_emit;
        logic out_free;
        logic hold_valid;
        logic item_last;
    } status_t;

    // ascii case folding, upper case letters map to lower case
    function automatic logic [BYTE_W-1:0] fold_char(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] max_len);
        return (len > max_len) ? max_len : len;
    endfunction

endpackage

[sv/nsfr_cfg.sv]
// register file behind the apb-style configuration port
module nsfr_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nsfr_pkg::APB_AW-1:0]   paddr,
    input  logic [nsfr_pkg::APB_DW-1:0]   pwdata,
    output logic [nsfr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output nsfr_pkg::cfg_t                cfg
);

    logic [nsfr_pkg::WORD_W-1:0] pattern_word_reg, pattern_word_next;
    logic [nsfr_pkg::LEN_W-1:0]  pattern_length_reg, pattern_length_next;
    logic [nsfr_pkg::WORD_W-1:0] replace_word_reg, replace_word_next;
    logic [nsfr_pkg::LEN_W-1:0]  replace_length_reg, replace_length_next;
    logic                        first_only_reg, first_only_next;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[5:3];

    always_comb
    begin
        pattern_word_next   = pattern_word_reg;
        pattern_length_next = pattern_length_reg;
        replace_word_next   = replace_word_reg;
        replace_length_next = replace_length_reg;
        first_only_next     = first_only_reg;
        if (wr_en)
        begin
            case (reg_idx)
                nsfr_pkg::REG_PATTERN_WORD:   pattern_word_next   = pwdata;
                nsfr_pkg::REG_PATTERN_LENGTH: pattern_length_next = pwdata[3:0];
                nsfr_pkg::REG_REPLACE_WORD:   replace_word_next   = pwdata;
                nsfr_pkg::REG_REPLACE_LENGTH: replace_length_next = pwdata[3:0];
                nsfr_pkg::REG_FIRST_ONLY:     first_only_next     = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_word_reg   <= '0;
            pattern_length_reg <= '0;
            replace_word_reg   <= '0;
            replace_length_reg <= '0;
            first_only_reg     <= 1'b0;
        end
        else
        begin
            pattern_word_reg   <= pattern_word_next;
            pattern_length_reg <= pattern_length_next;
            replace_word_reg   <= replace_word_next;
            replace_length_reg <= replace_length_next;
            first_only_reg     <= first_only_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            nsfr_pkg::REG_PATTERN_WORD:   prdata = pattern_word_reg;
            nsfr_pkg::REG_PATTERN_LENGTH: prdata = {60'd0, pattern_length_reg};
            nsfr_pkg::REG_REPLACE_WORD:   prdata = replace_word_reg;
            nsfr_pkg::REG_REPLACE_LENGTH: prdata = {60'd0, replace_length_reg};
            nsfr_pkg::REG_FIRST_ONLY:     prdata = {63'd0, first_only_reg};
            default:                      prdata = '0;
        endcase
    end

    // lengths above the maximum saturate
    assign cfg.pattern_word = pattern_word_reg;
    assign cfg.plen         = nsfr_pkg::sat_len(pattern_length_reg,
                                  nsfr_pkg::LEN_W'(nsfr_pkg::PATTERN_MAX));
    assign cfg.replace_word = replace_word_reg;
    assign cfg.rlen         = nsfr_pkg::sat_len(replace_length_reg,
                                  nsfr_pkg::LEN_W'(nsfr_pkg::REPLACE_MAX));
    assign cfg.first_only   = first_only_reg;

endmodule

[sv/nsfr_dp.sv]
// datapath: pending buffer, prefix compare, hold stage and output register
module nsfr_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nsfr_pkg::cfg_t                cfg,
    input  nsfr_pkg::cmd_t                cmd,
    output nsfr_pkg::status_t             sts,
    input  logic [nsfr_pkg::BYTE_W-1:0]   text_byte,
    input  logic                          end_of_text,
    output logic [nsfr_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last,
    output logic                          out_valid,
    input  logic                          out_stall
);

    logic [nsfr_pkg::BYTE_W-1:0] pend_reg [nsfr_pkg::PATTERN_MAX];
    logic [nsfr_pkg::BYTE_W-1:0] pend_next [nsfr_pkg::PATTERN_MAX];
    logic [nsfr_pkg::LEN_W-1:0]  count_reg, count_next;
    logic                        replaced_reg, replaced_next;
    logic [nsfr_pkg::LEN_W-1:0]  rep_idx_reg, rep_idx_next;
    logic [nsfr_pkg::BYTE_W-1:0] item_byte_reg, item_byte_next;
    logic                        item_last_reg, item_last_next;
    logic [nsfr_pkg::BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [nsfr_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_valid_reg, out_valid_next;

    logic                             pass_mode;
    logic                             out_free;
    logic                             pop;
    logic                             rep_inc;
    logic [nsfr_pkg::PATTERN_MAX-1:0] cmp_ok;
    logic                             prefix_ok;
    logic [nsfr_pkg::BYTE_W-1:0]      rep_byte;
    logic [nsfr_pkg::BYTE_W-1:0]      emit_byte;

    assign pass_mode = (cfg.plen == '0) || (cfg.first_only && replaced_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = cmd.emit && (cmd.emit_sel == nsfr_pkg::SEL_PEND);
    assign rep_inc   = cmd.emit && (cmd.emit_sel == nsfr_pkg::SEL_REPL);

    // per-position compare, positions at or beyond the count always pass
    always_comb
    begin
        for (int i = 0; i < nsfr_pkg::PATTERN_MAX; i++)
        begin
            cmp_ok[i] = (nsfr_pkg::LEN_W'(i) >= count_reg) ||
                        (nsfr_pkg::fold_char(pend_reg[i]) ==
                         nsfr_pkg::fold_char(cfg.pattern_word[i*8 +: 8]));
        end
    end

    assign prefix_ok = (count_reg <= cfg.plen) && (&cmp_ok);

    assign rep_byte = cfg.replace_word[rep_idx_reg[nsfr_pkg::REP_IW-1:0]*8 +: 8];

    always_comb
    begin
        case (cmd.emit_sel)
            nsfr_pkg::SEL_PEND: emit_byte = pend_reg[0];
            nsfr_pkg::SEL_ITEM: emit_byte = item_byte_reg;
            nsfr_pkg::SEL_REPL: emit_byte = rep_byte;
            default:            emit_byte = item_byte_reg;
        endcase
    end

    always_comb
    begin
        pend_next      = pend_reg;
        count_next     = count_reg;
        replaced_next  = replaced_reg;
        rep_idx_next   = rep_idx_reg;
        item_byte_next = item_byte_reg;
        item_last_next = item_last_reg;

        if (cmd.take_item)
        begin
            item_byte_next = text_byte;
            item_last_next = end_of_text;
            if (!pass_mode)
            begin
                pend_next[count_reg[nsfr_pkg::PEND_IW-1:0]] = text_byte;
                count_next = count_reg + 1'b1;
            end
        end
        if (pop)
        begin
            for (int i = 0; i < nsfr_pkg::PATTERN_MAX - 1; i++)
            begin
                pend_next[i] = pend_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
        if (rep_inc)
        begin
            rep_idx_next = rep_idx_reg + 1'b1;
        end
        if (cmd.begin_repl)
        begin
            count_next    = '0;
            rep_idx_next  = '0;
            replaced_next = 1'b1;
        end
        if (cmd.finish && item_last_reg)
        begin
            count_next    = '0;
            replaced_next = 1'b0;
        end
    end

    // one byte is always held back so the final byte of a text can carry last
    always_comb
    begin
        hold_byte_next  = hold_byte_reg;
        hold_valid_next = hold_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.emit)
        begin
            if (hold_valid_reg)
            begin
                out_byte_next  = hold_byte_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            hold_byte_next  = emit_byte;
            hold_valid_next = 1'b1;
        end
        else if (cmd.finish && hold_valid_reg)
        begin
            out_byte_next   = hold_byte_reg;
            out_last_next   = item_last_reg;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            replaced_reg   <= 1'b0;
            rep_idx_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            replaced_reg   <= replaced_next;
            rep_idx_reg    <= rep_idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        item_byte_reg <= item_byte_next;
        item_last_reg <= item_last_next;
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign sts.pass_mode  = pass_mode;
    assign sts.count_zero = (count_reg == '0);
    assign sts.prefix_ok  = prefix_ok;
    assign sts.full_match = prefix_ok && (count_reg == cfg.plen);
    assign sts.rep_done   = (rep_idx_reg >= cfg.rlen);
    assign sts.can_emit   = !hold_valid_reg || out_free;
    assign sts.out_free   = out_free;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.item_last  = item_last_reg;

    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

[sv/nsfr_ctrl.sv]
// controller state machine that sequences one text byte at a time
module nsfr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  nsfr_pkg::status_t sts,
    output nsfr_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FLUSH = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_REPL  = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = sts.pass_mode ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                if (sts.can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (!sts.count_zero)
                    begin
                        cmd.emit_sel = nsfr_pkg::SEL_PEND;
                    end
                    else
                    begin
                        cmd.emit_sel = nsfr_pkg::SEL_ITEM;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!sts.prefix_ok)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = nsfr_pkg::SEL_PEND;
                    end
                end
                else if (sts.full_match)
                begin
                    cmd.begin_repl = 1'b1;
                    state_next     = ST_REPL;
                end
                else
                begin
                    state_next = sts.item_last ? ST_TAIL : ST_DONE;
                end
            end
            ST_REPL:
            begin
                if (!sts.rep_done)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = nsfr_pkg::SEL_REPL;
                    end
                end
                else
                begin
                    state_next = sts.item_last ? ST_TAIL : ST_DONE;
                end
            end
            ST_TAIL:
            begin
                if (!sts.count_zero)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = nsfr_pkg::SEL_PEND;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.hold_valid || sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/nocase_stream_find_replace.sv]
// top level of the case-insensitive streaming find and replace block
// each input byte is taken in the idle state, then flushed in pass-through mode or scanned
//   and, on a match, replaced, with a tail flush at a text end; output bytes pass the hold
//   and output registers; a new input byte is taken only after the last one is finished,
//   and output stalls can hold the flow
// reset: rst_n clears config, counts, flags and state; pending and other bytes stay unreset
module nocase_stream_find_replace
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nsfr_pkg::APB_AW-1:0]   paddr,
    input  logic [nsfr_pkg::APB_DW-1:0]   pwdata,
    output logic [nsfr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // input text stream
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nsfr_pkg::BYTE_W-1:0]   text_byte,
    input  logic                          end_of_text,
    // rewritten text stream
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nsfr_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last
);

    nsfr_pkg::cfg_t    cfg;
    nsfr_pkg::cmd_t    cmd;
    nsfr_pkg::status_t sts;

    // registers, lengths arrive already saturated to the maxima
    nsfr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: take a byte, then flush, scan, replace and tail as needed
    nsfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // buffer, compare and output side; one byte is held back so the last
    // byte of a text is known before it leaves
    nsfr_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule
